// ----- src/vms_pkg.sv -----
package vms_pkg;
    localparam int NUM_PIX = 9;
    localparam int PIX_W = 24;
    localparam int IDX_W = 4;
    localparam int NUM_PAIRS = 36;
    localparam int FRAC_BITS_DEF = 8;
    localparam int D2_W = 18;
    localparam int REG_WINDOW_NINE = 0;
    localparam int REG_CHOOSE_MAX = 1;
    localparam int CFG_IDX_W = 1;

    typedef struct packed {
        logic window_nine;
        logic choose_max;
    } t_cfg;

    function automatic logic [IDX_W-1:0] pair_a(input int p);
        int k;
        int a;
        int b;
        k = 0;
        pair_a = '0;
        for (a = 0; a < NUM_PIX; a++) begin
            for (b = a + 1; b < NUM_PIX; b++) begin
                if (k == p) begin
                    pair_a = IDX_W'(a);
                end
                k++;
            end
        end
    endfunction

    function automatic logic [IDX_W-1:0] pair_b(input int p);
        int k;
        int a;
        int b;
        k = 0;
        pair_b = '0;
        for (a = 0; a < NUM_PIX; a++) begin
            for (b = a + 1; b < NUM_PIX; b++) begin
                if (k == p) begin
                    pair_b = IDX_W'(b);
                end
                k++;
            end
        end
    endfunction
endpackage

// ----- src/vms_if.sv -----
interface vms_if #(parameter int W = 24) (input logic i_clk);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- src/vms_sqrt_lane.sv -----
// Pipelined integer square root: one result bit per stage.
module vms_sqrt_lane
    import vms_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int X_W = D2_W + FRAC_BITS,
    parameter int R_W = (X_W + 1) / 2
) (
    input  logic           i_clk,
    input  logic [X_W-1:0] i_x,
    input  logic           i_en,
    output logic [R_W-1:0] o_root
);
    localparam int XP_W = 2 * R_W;

    logic [XP_W-1:0] r_rem  [R_W];
    logic [R_W-1:0]  r_root [R_W];
    logic [XP_W-1:0] n_rem  [R_W];
    logic [R_W-1:0]  n_root [R_W];

    always_comb begin
        logic [XP_W+1:0] trial;
        logic [XP_W+1:0] remw;
        logic [R_W-1:0]  root_in;
        for (int s = 0; s < R_W; s++) begin
            if (s == 0) begin
                remw    = (XP_W+2)'(i_x);
                root_in = '0;
            end else begin
                remw    = (XP_W+2)'(r_rem[s-1]);
                root_in = r_root[s-1];
            end
            // (root + 2^bit)^2 - root^2 = root << (bit+1) | 1 << (2*bit)
            trial = ((XP_W+2)'(root_in) << (R_W - s))
                  | ((XP_W+2)'(1) << (2 * (R_W - 1 - s)));
            if (remw >= trial) begin
                n_rem[s]  = XP_W'(remw - trial);
                n_root[s] = root_in | (R_W'(1) << (R_W - 1 - s));
            end else begin
                n_rem[s]  = XP_W'(remw);
                n_root[s] = root_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < R_W; s++) begin
                r_rem[s]  <= n_rem[s];
                r_root[s] <= n_root[s];
            end
        end
    end

    assign o_root = r_root[R_W-1];
endmodule

// ----- src/vms_merge.sv -----
// Add distances per pixel and select the extreme sum; two registered stages.
module vms_merge
    import vms_pkg::*;
#(
    parameter int R_W = 13,
    parameter int S_W = R_W + 3
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [R_W-1:0]   i_dist [NUM_PAIRS],
    input  t_cfg             i_cfg,
    output logic [IDX_W-1:0] o_best
);
    logic [S_W-1:0] n_sum [NUM_PIX];
    logic [S_W-1:0] r_sum [NUM_PIX];
    t_cfg           r_cfg;
    logic [IDX_W-1:0] n_best;
    logic [IDX_W-1:0] r_best;

    always_comb begin
        for (int i = 0; i < NUM_PIX; i++) begin
            n_sum[i] = '0;
        end
        for (int p = 0; p < NUM_PAIRS; p++) begin
            if (i_cfg.window_nine || pair_b(p) < IDX_W'(4)) begin
                n_sum[pair_a(p)] = n_sum[pair_a(p)] + S_W'(i_dist[p]);
                n_sum[pair_b(p)] = n_sum[pair_b(p)] + S_W'(i_dist[p]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= n_sum;
            r_cfg <= i_cfg;
        end
    end

    always_comb begin
        logic [S_W-1:0] bs;
        bs     = r_sum[0];
        n_best = '0;
        for (int i = 1; i < NUM_PIX; i++) begin
            if (r_cfg.window_nine || i < 4) begin
                if (r_cfg.choose_max ? (r_sum[i] >= bs) : (r_sum[i] <= bs)) begin
                    bs     = r_sum[i];
                    n_best = IDX_W'(i);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_best <= n_best;
        end
    end

    assign o_best = r_best;
endmodule

// ----- src/vector_median_select.sv -----
// Vector median filter: takes one 9-pixel window per clock and returns the pixel
// whose summed Euclidean distance to the others is smallest (or largest with
// choose_max; a tie goes to the higher index). With window_nine clear only the
// first four pixels count. It chains squaring, 36 pipelined square root lanes (one
// bit per stage), summing and selection stages. Throughput is one window per clock; the
// whole pipeline holds when the output is stalled. Write configuration only while idle.
module vector_median_select
    import vms_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    vms_if.sink                  s_in,
    vms_if.source                m_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic                 i_cfg_data
);
    localparam int X_W = D2_W + FRAC_BITS;
    localparam int R_W = (X_W + 1) / 2;
    localparam int LAT = R_W + 3;

    t_cfg r_cfg;
    logic [PIX_W-1:0] w_pix [NUM_PIX];
    logic [PIX_W-1:0] r_pix [LAT][NUM_PIX];
    logic [LAT-1:0]   r_vld;
    logic             w_en;
    logic [D2_W-1:0]  n_d2 [NUM_PAIRS];
    logic [D2_W-1:0]  r_d2 [NUM_PAIRS];
    logic [R_W-1:0]   w_root [NUM_PAIRS];
    logic [IDX_W-1:0] w_best;

    assign w_en       = !r_vld[LAT-1] || m_out.ready;
    assign s_in.ready = w_en;

    always_comb begin
        for (int i = 0; i < NUM_PIX; i++) begin
            w_pix[i] = s_in.data[i*PIX_W +: PIX_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDX_W'(REG_WINDOW_NINE): r_cfg.window_nine <= i_cfg_data;
                CFG_IDX_W'(REG_CHOOSE_MAX):  r_cfg.choose_max  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], s_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pix[0] <= w_pix;
            for (int s = 1; s < LAT; s++) begin
                r_pix[s] <= r_pix[s-1];
            end
        end
    end

    // squared distance per pair, one lane each
    always_comb begin
        for (int p = 0; p < NUM_PAIRS; p++) begin
            logic [8:0] d;
            n_d2[p] = '0;
            for (int c = 0; c < 3; c++) begin
                d = 9'(w_pix[pair_a(p)][c*8 +: 8]) - 9'(w_pix[pair_b(p)][c*8 +: 8]);
                if (d[8]) d = -d;
                n_d2[p] = n_d2[p] + D2_W'(d[7:0] * d[7:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d2 <= n_d2;
        end
    end

    genvar p;
    generate
        for (p = 0; p < NUM_PAIRS; p++) begin : g_lane
            vms_sqrt_lane #(.FRAC_BITS(FRAC_BITS), .X_W(X_W), .R_W(R_W)) u_sqrt (
                .i_clk  (i_clk),
                .i_x    ({r_d2[p], FRAC_BITS'(0)}),
                .i_en   (w_en),
                .o_root (w_root[p])
            );
        end
    endgenerate

    vms_merge #(.R_W(R_W)) u_merge (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_dist (w_root),
        .i_cfg  (r_cfg),
        .o_best (w_best)
    );

    assign m_out.valid = r_vld[LAT-1];
    assign m_out.data  = {r_pix[LAT-1][w_best], w_best};

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && !m_out.ready |=> m_out.valid)
        else $error("result dropped while stalled");
    a_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid |-> w_best < IDX_W'(NUM_PIX))
        else $error("index out of window");
    a_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && !r_cfg.window_nine |-> w_best < IDX_W'(4))
        else $error("index outside 2x2 window");
endmodule
